// ----- rtl/wss_pkg.sv -----
`timescale 1ns / 1ps
package wss_pkg;
    localparam int WORD_SLOTS   = 1024;
    localparam int MAX_WORD_LEN = 50;
    localparam int BIN_COUNT    = MAX_WORD_LEN + 1;
    localparam int SLOT_W       = $clog2(WORD_SLOTS);
    localparam int CNT_W        = $clog2(WORD_SLOTS + 1);
    localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
    localparam int CHAR_W       = $clog2(WORD_SLOTS * MAX_WORD_LEN + 1);
    localparam int CHAR_DEPTH   = WORD_SLOTS * (2 ** LEN_W);
    localparam int NUM_REC      = 4 + BIN_COUNT;
    localparam int REC_W        = $clog2(NUM_REC);
    localparam int STAT_W       = 17;
    localparam int BIN_W        = 6;
    localparam int KIND_W       = 3;

    localparam logic [1:0] FUNC_CHAR = 2'd0;
    localparam logic [1:0] FUNC_WEND = 2'd1;
    localparam logic [1:0] FUNC_TEND = 2'd2;

    localparam logic [KIND_W-1:0] KIND_WORDS    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CHARS    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SPACED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DISTINCT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BIN      = 3'd4;
endpackage

// ----- rtl/wss_hist_cell.sv -----
`timescale 1ns / 1ps
module wss_hist_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    bump,
    input  logic                    shift,
    input  logic [wss_pkg::CNT_W-1:0] count_in,
    output logic [wss_pkg::CNT_W-1:0] count
);
    logic [wss_pkg::CNT_W-1:0] count_reg;
    logic [wss_pkg::CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (shift)
        begin
            count_next = count_in;
        end
        else if (bump)
        begin
            count_next = count_reg + wss_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;
endmodule

// ----- rtl/wss_hist_chain.sv -----
`timescale 1ns / 1ps
module wss_hist_chain (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      bump_en,
    input  logic [wss_pkg::LEN_W-1:0] bump_len,
    input  logic                      shift,
    output logic [wss_pkg::CNT_W-1:0] head
);
    logic [wss_pkg::CNT_W-1:0] counts [wss_pkg::BIN_COUNT];

    // bins move one place toward the head per shift, zeros enter at the tail
    for (genvar b = 0; b < wss_pkg::BIN_COUNT; b++)
    begin : g_cell
        logic [wss_pkg::CNT_W-1:0] feed;
        if (b == wss_pkg::BIN_COUNT - 1)
        begin : g_tail
            assign feed = '0;
        end
        else
        begin : g_mid
            assign feed = counts[b + 1];
        end
        wss_hist_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .bump     (bump_en && (bump_len == wss_pkg::LEN_W'(b))),
            .shift    (shift),
            .count_in (feed),
            .count    (counts[b])
        );
    end

    assign head = counts[0];
endmodule

// ----- rtl/word_stream_statistics.sv -----
`timescale 1ns / 1ps
// word statistics over a byte stream. a character, an empty word end or a word
// end with every slot in use is taken without a stall. a word end that stores
// a word then scans earlier words until the first match: each one's length is
// checked, and for an equal length each character is compared; a close-out
// state then counts the word. the scan is paced by the stored character
// memory, which is read once per compare step. a text end closes the pending
// word and then sends 55 records, one per cycle unless rec_stall holds them;
// the histogram leaves through its shift chain and is zero after.
module word_stream_statistics (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         src_valid,
    output logic                         src_stall,
    input  logic [1:0]                   func,
    input  logic [7:0]                   char_code,
    output logic                         rec_valid,
    input  logic                         rec_stall,
    output logic [wss_pkg::KIND_W-1:0]   record_kind,
    output logic [wss_pkg::BIN_W-1:0]    bin_index,
    output logic signed [wss_pkg::STAT_W-1:0] stat_value,
    output logic                         last_record
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LREAD = 7'b0000010,
        S_LCHK  = 7'b0000100,
        S_CREAD = 7'b0001000,
        S_CCHK  = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [wss_pkg::CNT_W-1:0]  words_reg, words_next;
    logic [wss_pkg::CHAR_W-1:0] chars_reg, chars_next;
    logic [wss_pkg::CNT_W-1:0]  dist_reg, dist_next;
    logic [wss_pkg::LEN_W-1:0]  cur_reg, cur_next;
    logic [wss_pkg::SLOT_W-1:0] k_reg, k_next;
    logic [wss_pkg::LEN_W-1:0]  i_reg, i_next;
    logic                       seen_reg, seen_next;
    logic                       tend_reg, tend_next;
    logic [wss_pkg::REC_W-1:0]  rec_reg, rec_next;

    logic                       ovalid_reg, ovalid_next;
    logic [wss_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [wss_pkg::BIN_W-1:0]  bin_reg, bin_next;
    logic [wss_pkg::STAT_W-1:0] stat_reg, stat_next;
    logic                       last_reg, last_next;

    logic [7:0]                 char_mem [wss_pkg::CHAR_DEPTH];
    logic [wss_pkg::LEN_W-1:0]  len_mem  [wss_pkg::WORD_SLOTS];
    logic [7:0]                 rd_old, rd_new;
    logic [wss_pkg::LEN_W-1:0]  rd_len;

    logic                       accept, char_we, len_we, room;
    logic [wss_pkg::SLOT_W-1:0] slot;
    logic                       hist_bump, hist_shift;
    logic [wss_pkg::CNT_W-1:0]  hist_head;
    logic [wss_pkg::REC_W-1:0]  bin_rec;

    assign accept = src_valid && !src_stall;
    assign slot   = words_reg[wss_pkg::SLOT_W-1:0];
    assign room   = words_reg < wss_pkg::CNT_W'(wss_pkg::WORD_SLOTS);
    assign char_we = accept && (func == wss_pkg::FUNC_CHAR) && (char_code != 8'd0)
                     && (cur_reg < wss_pkg::LEN_W'(wss_pkg::MAX_WORD_LEN)) && room;
    assign len_we = accept && ((func == wss_pkg::FUNC_WEND) || (func == wss_pkg::FUNC_TEND))
                    && (cur_reg != '0) && room;

    always_ff @(posedge clk)
    begin
        if (char_we)
        begin
            char_mem[{slot, cur_reg}] <= char_code;
        end
        rd_old <= char_mem[{k_reg, i_reg}];
        rd_new <= char_mem[{slot, i_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[slot] <= cur_reg;
        end
        rd_len <= len_mem[k_reg];
    end

    wss_hist_chain u_hist (
        .clk      (clk),
        .rst_n    (rst_n),
        .bump_en  (hist_bump),
        .bump_len (cur_reg),
        .shift    (hist_shift),
        .head     (hist_head)
    );

    assign bin_rec = rec_reg - wss_pkg::REC_W'(4);

    always_comb
    begin
        state_next  = state_reg;
        words_next  = words_reg;
        chars_next  = chars_reg;
        dist_next   = dist_reg;
        cur_next    = cur_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        seen_next   = seen_reg;
        tend_next   = tend_reg;
        rec_next    = rec_reg;
        ovalid_next = ovalid_reg && rec_stall;
        kind_next   = kind_reg;
        bin_next    = bin_reg;
        stat_next   = stat_reg;
        last_next   = last_reg;
        hist_bump   = 1'b0;
        hist_shift  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (func == wss_pkg::FUNC_CHAR)
                    begin
                        if ((char_code != 8'd0) &&
                            (cur_reg < wss_pkg::LEN_W'(wss_pkg::MAX_WORD_LEN)))
                        begin
                            cur_next = cur_reg + wss_pkg::LEN_W'(1);
                        end
                    end
                    else if ((func == wss_pkg::FUNC_WEND) || (func == wss_pkg::FUNC_TEND))
                    begin
                        tend_next = (func == wss_pkg::FUNC_TEND);
                        rec_next  = '0;
                        if ((cur_reg != '0) && room)
                        begin
                            seen_next = 1'b0;
                            k_next    = '0;
                            state_next = (words_reg == '0) ? S_FIN : S_LREAD;
                        end
                        else
                        begin
                            cur_next = '0;
                            if (func == wss_pkg::FUNC_TEND)
                            begin
                                state_next = S_EMIT;
                            end
                        end
                    end
                end
            end
            S_LREAD:
            begin
                state_next = S_LCHK;
            end
            S_LCHK:
            begin
                if (rd_len == cur_reg)
                begin
                    i_next     = '0;
                    state_next = S_CREAD;
                end
                else if (wss_pkg::CNT_W'(k_reg) == words_reg - wss_pkg::CNT_W'(1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    k_next     = k_reg + wss_pkg::SLOT_W'(1);
                    state_next = S_LREAD;
                end
            end
            S_CREAD:
            begin
                state_next = S_CCHK;
            end
            S_CCHK:
            begin
                if (rd_old != rd_new)
                begin
                    if (wss_pkg::CNT_W'(k_reg) == words_reg - wss_pkg::CNT_W'(1))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        k_next     = k_reg + wss_pkg::SLOT_W'(1);
                        state_next = S_LREAD;
                    end
                end
                else if (i_reg == cur_reg - wss_pkg::LEN_W'(1))
                begin
                    seen_next  = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    i_next     = i_reg + wss_pkg::LEN_W'(1);
                    state_next = S_CREAD;
                end
            end
            S_FIN:
            begin
                hist_bump  = 1'b1;
                words_next = words_reg + wss_pkg::CNT_W'(1);
                chars_next = chars_reg + wss_pkg::CHAR_W'(cur_reg);
                if (!seen_reg)
                begin
                    dist_next = dist_reg + wss_pkg::CNT_W'(1);
                end
                cur_next   = '0;
                state_next = tend_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (!ovalid_reg || !rec_stall)
                begin
                    ovalid_next = 1'b1;
                    bin_next    = '0;
                    last_next   = 1'b0;
                    priority if (rec_reg == wss_pkg::REC_W'(0))
                    begin
                        kind_next = wss_pkg::KIND_WORDS;
                        stat_next = wss_pkg::STAT_W'(words_reg);
                    end
                    else if (rec_reg == wss_pkg::REC_W'(1))
                    begin
                        kind_next = wss_pkg::KIND_CHARS;
                        stat_next = wss_pkg::STAT_W'(chars_reg);
                    end
                    else if (rec_reg == wss_pkg::REC_W'(2))
                    begin
                        kind_next = wss_pkg::KIND_SPACED;
                        stat_next = wss_pkg::STAT_W'(words_reg) + wss_pkg::STAT_W'(chars_reg)
                                    - wss_pkg::STAT_W'(1);
                    end
                    else if (rec_reg == wss_pkg::REC_W'(3))
                    begin
                        kind_next = wss_pkg::KIND_DISTINCT;
                        stat_next = wss_pkg::STAT_W'(dist_reg);
                    end
                    else
                    begin
                        kind_next  = wss_pkg::KIND_BIN;
                        bin_next   = wss_pkg::BIN_W'(bin_rec);
                        stat_next  = wss_pkg::STAT_W'(hist_head);
                        hist_shift = 1'b1;
                        last_next  = (rec_reg == wss_pkg::REC_W'(wss_pkg::NUM_REC - 1));
                    end
                    rec_next = rec_reg + wss_pkg::REC_W'(1);
                    if (rec_reg == wss_pkg::REC_W'(wss_pkg::NUM_REC - 1))
                    begin
                        words_next = '0;
                        chars_next = '0;
                        dist_next  = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            words_reg  <= '0;
            chars_reg  <= '0;
            dist_reg   <= '0;
            cur_reg    <= '0;
            k_reg      <= '0;
            i_reg      <= '0;
            seen_reg   <= 1'b0;
            tend_reg   <= 1'b0;
            rec_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            words_reg  <= words_next;
            chars_reg  <= chars_next;
            dist_reg   <= dist_next;
            cur_reg    <= cur_next;
            k_reg      <= k_next;
            i_reg      <= i_next;
            seen_reg   <= seen_next;
            tend_reg   <= tend_next;
            rec_reg    <= rec_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        bin_reg  <= bin_next;
        stat_reg <= stat_next;
        last_reg <= last_next;
    end

    assign src_stall   = (state_reg != S_IDLE);
    assign rec_valid   = ovalid_reg;
    assign record_kind = kind_reg;
    assign bin_index   = bin_reg;
    assign stat_value  = stat_reg;
    assign last_record = last_reg;
endmodule
